/* design/piw_pkg.sv */
package piw_pkg;

    localparam int COORD_BITS   = 16;
    localparam int REL_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * REL_BITS;
    localparam int WIND_BITS    = 13;
    localparam int WIND_LIMIT   = 2048;
    localparam int S_TDATA_BITS = 4 * COORD_BITS;
    localparam int M_TDATA_BITS = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0] quad_t;
    typedef logic signed [REL_BITS-1:0] rel_t;
    typedef logic signed [WIND_BITS-1:0] wind_t;

    // quadrant by {y < 0, x < 0}
    localparam quad_t QUAD_OF [2][2] = '{'{2'd0, 2'd1}, '{2'd3, 2'd2}};

    localparam logic signed [2:0] D_NEG3 = -3'sd3;
    localparam logic signed [2:0] D_NEG2 = -3'sd2;
    localparam logic signed [2:0] D_POS2 = 3'sd2;
    localparam logic signed [2:0] D_POS3 = 3'sd3;

    typedef enum logic [2:0] {
        EDGE_NONE,
        EDGE_INC,
        EDGE_DEC,
        EDGE_INC_GE,
        EDGE_DEC_LT
    } edge_kind_t;

    typedef struct packed {
        rel_t       prev_x;
        rel_t       prev_y;
        rel_t       cur_x;
        rel_t       cur_y;
        rel_t       first_x;
        rel_t       first_y;
        edge_kind_t kind_in;
        edge_kind_t kind_close;
        logic       first;
        logic       last;
    } vtx_req_t;

    function automatic quad_t quadrant(input rel_t x, input rel_t y);
        return QUAD_OF[y[REL_BITS-1]][x[REL_BITS-1]];
    endfunction

    function automatic edge_kind_t classify(input quad_t pq, input quad_t cq);
        logic signed [2:0] d;
        edge_kind_t k;
        d = $signed({1'b0, cq}) - $signed({1'b0, pq});
        case (d)
            D_NEG3:  k = EDGE_INC;
            D_POS3:  k = EDGE_DEC;
            D_NEG2:  k = EDGE_INC_GE;
            D_POS2:  k = EDGE_DEC_LT;
            default: k = EDGE_NONE;
        endcase
        return k;
    endfunction

    function automatic wind_t wind_step(input wind_t w, input edge_kind_t k, input logic ge);
        logic inc;
        logic dec;
        wind_t r;
        inc = (k == EDGE_INC) || ((k == EDGE_INC_GE) && ge);
        dec = (k == EDGE_DEC) || ((k == EDGE_DEC_LT) && !ge);
        r = w;
        if (inc && (w != wind_t'(WIND_LIMIT))) begin
            r = w + wind_t'(1);
        end else if (dec && (w != -wind_t'(WIND_LIMIT))) begin
            r = w - wind_t'(1);
        end
        return r;
    endfunction

endpackage

/* design/piw_front.sv */
module piw_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          acc,
    input  logic [piw_pkg::S_TDATA_BITS-1:0] tdata,
    input  logic                          tlast,
    output piw_pkg::vtx_req_t             req
);

    logic                        in_progress_reg;
    logic [piw_pkg::COORD_BITS-1:0] held_x_reg, held_y_reg;
    piw_pkg::rel_t               first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    piw_pkg::quad_t              first_q_reg, prev_q_reg;

    logic [piw_pkg::COORD_BITS-1:0] pt_x, pt_y, vx, vy;
    piw_pkg::rel_t               rx, ry, fx, fy;
    piw_pkg::quad_t              q, fq;

    localparam int CB = piw_pkg::COORD_BITS;

    always_comb begin
        pt_x = in_progress_reg ? held_x_reg : tdata[CB-1:0];
        pt_y = in_progress_reg ? held_y_reg : tdata[2*CB-1:CB];
        vx   = tdata[3*CB-1:2*CB];
        vy   = tdata[4*CB-1:3*CB];
        rx   = $signed({vx[CB-1], vx}) - $signed({pt_x[CB-1], pt_x});
        ry   = $signed({vy[CB-1], vy}) - $signed({pt_y[CB-1], pt_y});
        q    = piw_pkg::quadrant(rx, ry);
        fx   = in_progress_reg ? first_x_reg : rx;
        fy   = in_progress_reg ? first_y_reg : ry;
        fq   = in_progress_reg ? first_q_reg : q;

        req.prev_x     = prev_x_reg;
        req.prev_y     = prev_y_reg;
        req.cur_x      = rx;
        req.cur_y      = ry;
        req.first_x    = fx;
        req.first_y    = fy;
        req.kind_in    = piw_pkg::classify(prev_q_reg, q);
        req.kind_close = piw_pkg::classify(q, fq);
        req.first      = !in_progress_reg;
        req.last       = tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_progress_reg <= 1'b0;
        end else if (acc) begin
            in_progress_reg <= !tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            held_x_reg  <= pt_x;
            held_y_reg  <= pt_y;
            first_x_reg <= fx;
            first_y_reg <= fy;
            first_q_reg <= fq;
            prev_x_reg  <= rx;
            prev_y_reg  <= ry;
            prev_q_reg  <= q;
        end
    end

endmodule

/* design/piw_queue.sv */
module piw_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  piw_pkg::vtx_req_t push_req,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output piw_pkg::vtx_req_t head
);

    piw_pkg::vtx_req_t mem_reg [piw_pkg::QUEUE_DEPTH];
    logic [piw_pkg::QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [piw_pkg::QCNT_BITS-1:0] count_reg, count_next;

    assign full  = count_reg == piw_pkg::QCNT_BITS'(piw_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

/* design/piw_back.sv */
module piw_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  piw_pkg::vtx_req_t                q_head,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [piw_pkg::M_TDATA_BITS-1:0] m_tdata
);

    localparam int PB = piw_pkg::PROD_BITS;

    // stage A: cross products
    logic                        a_valid_reg;
    logic signed [PB-1:0]        in_l_reg, in_r_reg, cl_l_reg, cl_r_reg;
    piw_pkg::edge_kind_t         a_kind_in_reg, a_kind_close_reg;
    logic                        a_first_reg, a_last_reg;
    logic signed [PB-1:0]        in_l, in_r, cl_l, cl_r;

    // stage B: winding accumulation and result register
    piw_pkg::wind_t              winding_reg, winding_next;
    logic [1:0]                  tally_reg, tally_next;
    logic                        m_valid_reg;
    logic                        out_inside_reg, out_few_reg;
    piw_pkg::wind_t              out_wind_reg;
    piw_pkg::wind_t              w_in, w_close;
    logic                        out_free, b_go, a_ready, few;

    assign in_l = q_head.prev_x * q_head.cur_y;
    assign in_r = q_head.prev_y * q_head.cur_x;
    assign cl_l = q_head.cur_x * q_head.first_y;
    assign cl_r = q_head.cur_y * q_head.first_x;

    assign out_free = !m_valid_reg || m_tready;
    assign b_go     = a_valid_reg && (!a_last_reg || out_free);
    assign a_ready  = !a_valid_reg || b_go;
    assign q_pop    = !q_empty && a_ready;

    always_comb begin
        if (a_first_reg) begin
            w_in       = '0;
            tally_next = 2'd1;
        end else begin
            w_in       = piw_pkg::wind_step(winding_reg, a_kind_in_reg, in_l_reg >= in_r_reg);
            tally_next = (tally_reg == 2'd3) ? 2'd3 : tally_reg + 2'd1;
        end
        w_close      = piw_pkg::wind_step(w_in, a_kind_close_reg, cl_l_reg >= cl_r_reg);
        winding_next = a_last_reg ? w_close : w_in;
        few          = tally_next != 2'd3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            winding_reg <= '0;
            tally_reg   <= '0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= !q_empty;
            end
            if (b_go) begin
                winding_reg <= winding_next;
                tally_reg   <= tally_next;
            end
            if (b_go && a_last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            in_l_reg         <= in_l;
            in_r_reg         <= in_r;
            cl_l_reg         <= cl_l;
            cl_r_reg         <= cl_r;
            a_kind_in_reg    <= q_head.kind_in;
            a_kind_close_reg <= q_head.kind_close;
            a_first_reg      <= q_head.first;
            a_last_reg       <= q_head.last;
        end
        if (b_go && a_last_reg) begin
            out_few_reg    <= few;
            out_wind_reg   <= few ? '0 : w_close;
            out_inside_reg <= !few && (w_close != '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_few_reg, out_wind_reg, out_inside_reg};

endmodule

/* design/point_in_polygon_winding.sv */
// Quadrant winding-number point-in-polygon test. Vertices stream in one per
// request; the test point is taken from the first vertex of each polygon and
// ignored afterwards, and tlast marks the closing vertex. One result leaves
// per polygon, after its last vertex. The block takes one vertex per cycle
// while the queue is not full; a result passes through the queue, then the
// cross-product stage, then the winding stage and result register. A 4-entry
// queue between the vertex front end and the product/winding back end lets
// input keep flowing while the result side is stalled: once a closing vertex
// waits behind an unaccepted result, up to 4 more vertices are taken before
// s_tready drops. Polygons with fewer than three vertices report
// too_few_vertices with inside 0 and a zero count; the count saturates at
// +/-2048.
module point_in_polygon_winding (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // point_x, point_y, vertex_x, vertex_y
    input  logic [piw_pkg::S_TDATA_BITS-1:0] s_tdata,
    // last_vertex
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // inside_res, winding_count, too_few_vertices, zero pad
    output logic [piw_pkg::M_TDATA_BITS-1:0] m_tdata
);

    piw_pkg::vtx_req_t fe_req, q_head;
    logic q_full, q_empty, q_pop, acc;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    piw_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .acc     (acc),
        .tdata   (s_tdata),
        .tlast   (s_tlast),
        .req     (fe_req)
    );

    piw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (acc),
        .push_req (fe_req),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    piw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* design/piw_checker.sv */
module piw_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [piw_pkg::S_TDATA_BITS-1:0] s_tdata,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [piw_pkg::M_TDATA_BITS-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_few: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> !m_tdata[0] && (m_tdata[13:1] == 13'd0))
        else $error("short polygon reported a count");

    a_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == (!m_tdata[14] && (m_tdata[13:1] != 13'd0)))
        else $error("inside flag disagrees with count");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[13:1]) <= 13'sd2048)
                  && ($signed(m_tdata[13:1]) >= -13'sd2048))
        else $error("winding count out of range");

endmodule

bind point_in_polygon_winding piw_checker u_piw_checker (.*);

/* tb/winding_monitor.sv */
`timescale 1ns / 1ps

module winding_monitor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [piw_pkg::S_TDATA_BITS-1:0] s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [piw_pkg::M_TDATA_BITS-1:0] m_tdata,
    output int                               mismatch_count,
    output int                               pending_verdicts
);

    // quadrant codes by sign of (x, y)
    localparam logic [1:0] QUAD_PP = 2'd0;
    localparam logic [1:0] QUAD_NP = 2'd1;
    localparam logic [1:0] QUAD_NN = 2'd2;
    localparam logic [1:0] QUAD_PN = 2'd3;

    // quadrant jumps from previous to current vertex
    localparam int WRAP_UP    = -3;
    localparam int WRAP_DOWN  = 3;
    localparam int DIAG_DOWN  = -2;
    localparam int DIAG_UP    = 2;

    typedef struct packed {
        logic           in_poly;
        piw_pkg::wind_t count;
        logic           few;
    } verdict_t;

    verdict_t expected_verdicts[$];
    verdict_t want;
    verdict_t got;

    logic                    busy;
    logic signed [piw_pkg::COORD_BITS-1:0] pt_x;
    logic signed [piw_pkg::COORD_BITS-1:0] pt_y;
    piw_pkg::rel_t           first_x;
    piw_pkg::rel_t           first_y;
    logic [1:0]              first_q;
    piw_pkg::rel_t           prev_x;
    piw_pkg::rel_t           prev_y;
    logic [1:0]              prev_q;
    int                      wind;
    int                      tally;

    initial begin
        mismatch_count   = 0;
        pending_verdicts = 0;
    end

    function automatic logic [1:0] quad_code(input piw_pkg::rel_t x, input piw_pkg::rel_t y);
        logic [1:0] q;
        if (y < 0) begin
            q = (x < 0) ? QUAD_NN : QUAD_PN;
        end else begin
            q = (x < 0) ? QUAD_NP : QUAD_PP;
        end
        return q;
    endfunction

    function automatic int crossing(input piw_pkg::rel_t px, input piw_pkg::rel_t py,
                                    input logic [1:0] pq,
                                    input piw_pkg::rel_t cx, input piw_pkg::rel_t cy,
                                    input logic [1:0] cq);
        int  d;
        int  step;
        logic turns_left;
        d = int'(cq) - int'(pq);
        turns_left = (longint'(px) * longint'(cy)) >= (longint'(py) * longint'(cx));
        step = 0;
        case (d)
            WRAP_UP:   step = 1;
            WRAP_DOWN: step = -1;
            DIAG_DOWN: step = turns_left ? 1 : 0;
            DIAG_UP:   step = turns_left ? 0 : -1;
            default:   step = 0;
        endcase
        return step;
    endfunction

    function automatic int clamp_wind(input int w);
        int r;
        r = w;
        if (r > piw_pkg::WIND_LIMIT) r = piw_pkg::WIND_LIMIT;
        if (r < -piw_pkg::WIND_LIMIT) r = -piw_pkg::WIND_LIMIT;
        return r;
    endfunction

    task automatic absorb_vertex(input logic [piw_pkg::S_TDATA_BITS-1:0] word,
                                 input logic closing);
        piw_pkg::rel_t rx;
        piw_pkg::rel_t ry;
        logic [1:0]    q;
        verdict_t      v;
        if (!busy) begin
            pt_x  = word[piw_pkg::COORD_BITS-1:0];
            pt_y  = word[2*piw_pkg::COORD_BITS-1:piw_pkg::COORD_BITS];
            wind  = 0;
            tally = 0;
        end
        rx = $signed(word[3*piw_pkg::COORD_BITS-1:2*piw_pkg::COORD_BITS]) - pt_x;
        ry = $signed(word[4*piw_pkg::COORD_BITS-1:3*piw_pkg::COORD_BITS]) - pt_y;
        q  = quad_code(rx, ry);
        if (!busy) begin
            first_x = rx;
            first_y = ry;
            first_q = q;
        end else begin
            wind = clamp_wind(wind + crossing(prev_x, prev_y, prev_q, rx, ry, q));
        end
        if (tally < 3) tally++;
        prev_x = rx;
        prev_y = ry;
        prev_q = q;
        if (!closing) begin
            busy = 1'b1;
        end else begin
            wind = clamp_wind(wind + crossing(rx, ry, q, first_x, first_y, first_q));
            busy = 1'b0;
            v.few     = (tally < 3);
            v.count   = v.few ? piw_pkg::wind_t'(0) : piw_pkg::wind_t'(wind);
            v.in_poly = !v.few && (wind != 0);
            expected_verdicts = {expected_verdicts, v};
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            busy   = 1'b0;
            pt_x   = '0;
            pt_y   = '0;
            first_x = '0;
            first_y = '0;
            first_q = QUAD_PP;
            prev_x = '0;
            prev_y = '0;
            prev_q = QUAD_PP;
            wind   = 0;
            tally  = 0;
            expected_verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.in_poly = m_tdata[0];
                got.count   = m_tdata[piw_pkg::WIND_BITS:1];
                got.few     = m_tdata[piw_pkg::WIND_BITS+1];
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.in_poly !== want.in_poly) begin
                        $display("%0t: inside_res expected %0d got %0d",
                                 $time, want.in_poly, got.in_poly);
                        mismatch_count++;
                    end
                    if (got.count !== want.count) begin
                        $display("%0t: winding_count expected %0d got %0d",
                                 $time, want.count, got.count);
                        mismatch_count++;
                    end
                    if (got.few !== want.few) begin
                        $display("%0t: too_few_vertices expected %0d got %0d",
                                 $time, want.few, got.few);
                        mismatch_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_vertex(s_tdata, s_tlast);
            end
        end
        pending_verdicts = expected_verdicts.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_VERTICES = 500;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 12;

    typedef logic signed [piw_pkg::COORD_BITS-1:0] coord_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [piw_pkg::S_TDATA_BITS-1:0] s_tdata  = '0;
    logic                             s_tlast  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [piw_pkg::M_TDATA_BITS-1:0] m_tdata;

    int mismatch_count;
    int pending_verdicts;

    bit no_idle   = 1'b0;
    bit hold_req  = 1'b0;
    int random_sent = 0;

    coord_t ring_x[$];
    coord_t ring_y[$];

    point_in_polygon_winding dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    winding_monitor monitor (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .pending_verdicts (pending_verdicts)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // result side: random ready runs, one long hold-off on request
    initial begin
        int  hold_left;
        int  run_left;
        bit  level;
        hold_left = 0;
        run_left  = 0;
        level     = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    level    = ($urandom_range(0, 3) != 0);
                    run_left = level ? $urandom_range(1, 20) : idle_len();
                end
                m_tready <= level;
                run_left--;
            end
        end
    end

    task automatic send_vertex(input coord_t px, input coord_t py,
                               input coord_t vx, input coord_t vy, input bit closing);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy, vx, py, px};
        s_tlast  <= closing;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic add_vertex(input int x, input int y);
        ring_x = {ring_x, coord_t'(x)};
        ring_y = {ring_y, coord_t'(y)};
    endtask

    // point fields after the first vertex are don't-care, so scramble them
    task automatic emit_polygon(input coord_t px, input coord_t py, input bit counted);
        int n;
        n = ring_x.size();
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                send_vertex(px, py, ring_x[i], ring_y[i], n == 1);
            end else begin
                send_vertex(coord_t'($urandom), coord_t'($urandom), ring_x[i], ring_y[i],
                            i == n - 1);
            end
            if (counted) random_sent++;
        end
        ring_x.delete();
        ring_y.delete();
    endtask

    task automatic fill_scatter(input int n);
        for (int i = 0; i < n; i++) begin
            add_vertex(int'(coord_t'($urandom)), int'(coord_t'($urandom)));
        end
    endtask

    // walk around the point quadrant by quadrant; occasional diagonal jumps and stalls
    task automatic fill_winding(input int cx, input int cy, input int n, input int spread);
        int q;
        int dir;
        int step;
        int ox;
        int oy;
        int r;
        q   = $urandom_range(0, 3);
        dir = $urandom_range(0, 1) ? 1 : 3;
        for (int i = 0; i < n; i++) begin
            ox = (q == 0 || q == 3) ? int'($urandom_range(0, spread))
                                    : -int'($urandom_range(1, spread));
            oy = (q == 0 || q == 1) ? int'($urandom_range(0, spread))
                                    : -int'($urandom_range(1, spread));
            add_vertex(cx + ox, cy + oy);
            r = $urandom_range(0, 9);
            step = (r == 0) ? 2 : (r == 1) ? 0 : dir;
            q = (q + step) % 4;
        end
    endtask

    initial begin
        int     kind;
        int     polygons;
        int     cx;
        int     cy;
        coord_t px;
        coord_t py;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lone vertex closes at once
        add_vertex(5, 5);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        // two vertices, point at the corner of the map
        add_vertex(32767, -32768);
        add_vertex(-32768, 32767);
        emit_polygon(-16'sd32768, 16'sd32767, 1'b0);
        // triangle around the point, both orientations
        add_vertex(10, -10);
        add_vertex(0, 10);
        add_vertex(-10, -10);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        add_vertex(-10, -10);
        add_vertex(0, 10);
        add_vertex(10, -10);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        // triangle off to one side
        add_vertex(100, 100);
        add_vertex(200, 100);
        add_vertex(150, 200);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        // diagonal edges through the point: cross-product ties
        add_vertex(1, 1);
        add_vertex(-1, -1);
        add_vertex(2, -3);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        add_vertex(-1, -1);
        add_vertex(1, 1);
        add_vertex(-3, 2);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        // full-range square around the point
        add_vertex(32767, 32767);
        add_vertex(-32768, 32767);
        add_vertex(-32768, -32768);
        add_vertex(32767, -32768);
        emit_polygon(16'sd0, 16'sd0, 1'b0);
        // point at the top corner, vertex on the point, largest negative offsets
        add_vertex(32767, 32767);
        add_vertex(-32768, 32767);
        add_vertex(-32768, -32768);
        emit_polygon(16'sd32767, 16'sd32767, 1'b0);

        hold_req = 1'b1;
        polygons = 0;
        while (random_sent < RANDOM_VERTICES) begin
            polygons++;
            no_idle = (polygons >= 30 && polygons < 45);
            kind = $urandom_range(0, 9);
            cx = int'($urandom_range(0, 16000)) - 8000;
            cy = int'($urandom_range(0, 16000)) - 8000;
            px = coord_t'(cx);
            py = coord_t'(cy);
            if (kind == 0) begin
                fill_scatter($urandom_range(1, 2));
                px = coord_t'($urandom);
                py = coord_t'($urandom);
            end else if (kind <= 2) begin
                fill_scatter($urandom_range(3, 8));
                px = coord_t'($urandom);
                py = coord_t'($urandom);
            end else if (kind == 3) begin
                fill_winding(cx, cy, $urandom_range(3, 12), 3);
            end else if (kind == 4 && $urandom_range(0, 3) == 0) begin
                fill_winding(cx, cy, $urandom_range(20, 40), 20000);
            end else begin
                fill_winding(cx, cy, $urandom_range(3, 12), 20000);
            end
            emit_polygon(px, py, 1'b1);
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_verdicts != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        if (mismatch_count == 0 && pending_verdicts == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
